/* rtl/nsfd_pkg.sv */
package nsfd_pkg;

  localparam int MAX_FRACTION_DIGITS_DEF = 5;
  localparam int USED_SAT_FIELDS_DEF     = 12;
  localparam int SATELLITE_SLOTS_DEF     = 36;

  // Sentence kinds.
  localparam logic [2:0] KIND_GPGSV = 3'd0;
  localparam logic [2:0] KIND_BDGSV = 3'd1;
  localparam logic [2:0] KIND_GNGGA = 3'd2;
  localparam logic [2:0] KIND_GNGSA = 3'd3;
  localparam logic [2:0] KIND_GNRMC = 3'd4;
  localparam logic [2:0] KIND_GNVTG = 3'd5;
  localparam logic [2:0] KIND_NONE  = 3'd7;

  // Quantity codes.
  localparam logic [4:0] Q_VISIBLE = 5'd0;
  localparam logic [4:0] Q_SATID   = 5'd1;
  localparam logic [4:0] Q_SNR     = 5'd4;
  localparam logic [4:0] Q_STATUS  = 5'd5;
  localparam logic [4:0] Q_USED    = 5'd6;
  localparam logic [4:0] Q_ALT     = 5'd7;
  localparam logic [4:0] Q_FIX     = 5'd8;
  localparam logic [4:0] Q_USEDID  = 5'd9;
  localparam logic [4:0] Q_PDOP    = 5'd10;
  localparam logic [4:0] Q_TIME    = 5'd13;
  localparam logic [4:0] Q_LAT     = 5'd14;
  localparam logic [4:0] Q_NS      = 5'd15;
  localparam logic [4:0] Q_LON     = 5'd16;
  localparam logic [4:0] Q_EW      = 5'd17;
  localparam logic [4:0] Q_DATE    = 5'd18;
  localparam logic [4:0] Q_SPEED   = 5'd19;
  localparam logic [4:0] Q_LAST    = 5'd19;

  // Characters.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  localparam logic [31:0] CENT        = 32'd100;
  localparam logic [31:0] MIN_PER_DEG = 32'd60;
  localparam logic [11:0] YEAR_BASE   = 12'd2000;
  localparam logic [6:0]  PART_CAP    = 7'd99;

  localparam int POW_W = 37;

  function automatic logic [POW_W-1:0] pow10(input logic [3:0] n);
    logic [POW_W-1:0] r;
    case (n)
      4'd0:    r = 37'd1;
      4'd1:    r = 37'd10;
      4'd2:    r = 37'd100;
      4'd3:    r = 37'd1000;
      4'd4:    r = 37'd10000;
      4'd5:    r = 37'd100000;
      4'd6:    r = 37'd1000000;
      4'd7:    r = 37'd10000000;
      4'd8:    r = 37'd100000000;
      4'd9:    r = 37'd1000000000;
      4'd10:   r = 37'd10000000000;
      4'd11:   r = 37'd100000000000;
      default: r = 37'd1;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] header_kind(input logic [39:0] h);
    logic [2:0] k;
    priority if (h == 40'("GPGSV")) k = KIND_GPGSV;
    else if (h == 40'("BDGSV"))     k = KIND_BDGSV;
    else if (h == 40'("GNGGA"))     k = KIND_GNGGA;
    else if (h == 40'("GNGSA"))     k = KIND_GNGSA;
    else if (h == 40'("GNRMC"))     k = KIND_GNRMC;
    else if (h == 40'("GNVTG"))     k = KIND_GNVTG;
    else                            k = KIND_NONE;
    return k;
  endfunction

endpackage

/* rtl/nmea_sentence_field_decoder.sv */
// NMEA sentence field decoder: one received character per input transaction, at most one decoded
// field per transaction on the result channel. A character that does not close a wanted field is
// taken without leaving the idle state. A character that closes one starts a small sequencer over
// one shared multiply-by-ten step and one shared 32-step restoring divider: building the value
// takes one multiply step per kept fraction digit, and each division takes all 32 steps. The input is
// not ready while a field is being worked on, or while its result waits for the output register
// to be free.
module nmea_sentence_field_decoder #(
  parameter int MAX_FRACTION_DIGITS = nsfd_pkg::MAX_FRACTION_DIGITS_DEF,
  parameter int USED_SAT_FIELDS     = nsfd_pkg::USED_SAT_FIELDS_DEF,
  parameter int SATELLITE_SLOTS     = nsfd_pkg::SATELLITE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_sentence_kind,
  output logic [4:0]         out_quantity,
  output logic [5:0]         out_slot,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_decimals,
  output logic [6:0]         out_part_high,
  output logic [6:0]         out_part_mid,
  output logic [11:0]        out_part_low,
  output logic [7:0]         out_hemisphere_char
);

  localparam int FL_W   = $clog2(MAX_FRACTION_DIGITS + 1);
  localparam int FRAC_W = $clog2(10 ** MAX_FRACTION_DIGITS);
  localparam logic [FL_W-1:0] MAXF       = FL_W'(MAX_FRACTION_DIGITS);
  localparam logic [4:0]      GSA_ID_END = 5'(3 + USED_SAT_FIELDS);
  localparam logic [5:0]      SLOT_LAST  = 6'(SATELLITE_SLOTS - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_NEXT = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  typedef enum logic [9:0] {
    PH_VAL    = 10'b0000000001,
    PH_SPEED  = 10'b0000000010,
    PH_T_DEC  = 10'b0000000100,
    PH_T_S    = 10'b0000001000,
    PH_T_M    = 10'b0000010000,
    PH_L_DEG  = 10'b0000100000,
    PH_L_SCL  = 10'b0001000000,
    PH_L_DOWN = 10'b0010000000,
    PH_L_60   = 10'b0100000000,
    PH_L_DEGX = 10'b1000000000
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  // Sentence and field scanning state.
  logic              in_sent_r, in_sent_nxt;
  logic [39:0]       hdr_r, hdr_nxt;
  logic [2:0]        kind_r, kind_nxt;
  logic [4:0]        fcnt_r, fcnt_nxt;
  logic [31:0]       iacc_r, iacc_nxt;
  logic [FRAC_W-1:0] facc_r, facc_nxt;
  logic [FL_W-1:0]   flen_r, flen_nxt;
  logic              minus_r, minus_nxt;
  logic              point_r, point_nxt;
  logic              bad_r, bad_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [5:0]        slot_r, slot_nxt;

  // Working registers of the sequencer.
  logic [4:0]        wf_r, wf_nxt;
  logic              wbad_r, wbad_nxt;
  logic              wminus_r, wminus_nxt;
  logic [FRAC_W-1:0] wfrac_r, wfrac_nxt;
  logic [FL_W-1:0]   dec_r, dec_nxt;
  logic [7:0]        whemi_r, whemi_nxt;
  logic [31:0]       mreg_r, mreg_nxt;
  logic [3:0]        mcnt_r, mcnt_nxt;
  logic [31:0]       dq_r, dq_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [nsfd_pkg::POW_W-1:0] dvs_r, dvs_nxt;
  logic [5:0]        dcnt_r, dcnt_nxt;
  logic [31:0]       deg_r, deg_nxt;
  logic [31:0]       val_r, val_nxt;
  logic [4:0]        rq_r, rq_nxt;
  logic [5:0]        rslot_r, rslot_nxt;
  logic [2:0]        rdec_r, rdec_nxt;
  logic [6:0]        rhi_r, rhi_nxt;
  logic [6:0]        rmid_r, rmid_nxt;
  logic [11:0]       rlo_r, rlo_nxt;
  logic [7:0]        rhemi_r, rhemi_nxt;

  logic              out_valid_r, out_valid_nxt;

  // Shared unit launch requests.
  logic                       div_go, mul_go;
  logic [31:0]                div_a, mul_a;
  logic [nsfd_pkg::POW_W-1:0] div_b;
  logic [3:0]                 mul_n;

  // Helpers.
  logic        b_comma, b_term, b_digit;
  logic [31:0] d32;
  logic [32:0] r2;
  logic        ge;
  logic [32:0] diff;
  logic [31:0] v;
  logic [FL_W-1:0] d;
  logic        emit;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  assign b_comma = (in_byte_in == nsfd_pkg::CH_COMMA);
  assign b_term  = (in_byte_in == nsfd_pkg::CH_STAR) || (in_byte_in < nsfd_pkg::CH_SPACE) ||
                   (in_byte_in > nsfd_pkg::CH_LOW_Z);
  assign b_digit = (in_byte_in >= nsfd_pkg::CH_ZERO) && (in_byte_in <= nsfd_pkg::CH_NINE);
  assign d32     = 32'(in_byte_in - nsfd_pkg::CH_ZERO);

  // One restoring division step.
  assign r2   = {rem_r, dq_r[31]};
  assign ge   = ({4'b0, r2} >= dvs_r);
  assign diff = r2 - dvs_r[32:0];

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    in_sent_nxt   = in_sent_r;
    hdr_nxt       = hdr_r;
    kind_nxt      = kind_r;
    fcnt_nxt      = fcnt_r;
    iacc_nxt      = iacc_r;
    facc_nxt      = facc_r;
    flen_nxt      = flen_r;
    minus_nxt     = minus_r;
    point_nxt     = point_r;
    bad_nxt       = bad_r;
    first_nxt     = first_r;
    slot_nxt      = slot_r;
    wf_nxt        = wf_r;
    wbad_nxt      = wbad_r;
    wminus_nxt    = wminus_r;
    wfrac_nxt     = wfrac_r;
    dec_nxt       = dec_r;
    whemi_nxt     = whemi_r;
    mreg_nxt      = mreg_r;
    mcnt_nxt      = mcnt_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    dcnt_nxt      = dcnt_r;
    deg_nxt       = deg_r;
    val_nxt       = val_r;
    rq_nxt        = rq_r;
    rslot_nxt     = rslot_r;
    rdec_nxt      = rdec_r;
    rhi_nxt       = rhi_r;
    rmid_nxt      = rmid_r;
    rlo_nxt       = rlo_r;
    rhemi_nxt     = rhemi_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_go        = 1'b0;
    div_a         = '0;
    div_b         = '0;
    mul_go        = 1'b0;
    mul_a         = '0;
    mul_n         = '0;
    v             = '0;
    d             = '0;
    emit          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_byte_in == nsfd_pkg::CH_DOLLAR) begin
            in_sent_nxt = 1'b1;
            hdr_nxt     = '0;
            kind_nxt    = nsfd_pkg::KIND_NONE;
            fcnt_nxt    = '0;
            iacc_nxt    = '0;
            facc_nxt    = '0;
            flen_nxt    = '0;
            minus_nxt   = 1'b0;
            point_nxt   = 1'b0;
            bad_nxt     = 1'b0;
            first_nxt   = '0;
          end else if (in_sent_r) begin
            if (b_comma || b_term) begin
              if (fcnt_r == 5'd0) begin
                if (b_comma) begin
                  kind_nxt = nsfd_pkg::header_kind(hdr_r);
                end
              end else if (kind_r != nsfd_pkg::KIND_NONE) begin
                wf_nxt     = fcnt_r;
                wbad_nxt   = bad_r || !(b_comma || (in_byte_in == nsfd_pkg::CH_STAR));
                wminus_nxt = minus_r;
                wfrac_nxt  = facc_r;
                dec_nxt    = flen_r;
                whemi_nxt  = (first_r != 8'd0) ? first_r : in_byte_in;
                phase_nxt  = PH_VAL;
                mul_go     = 1'b1;
                mul_a      = iacc_r;
                mul_n      = 4'(flen_r);
              end
              if (b_term) begin
                in_sent_nxt = 1'b0;
              end else begin
                if (fcnt_r != 5'd31) begin
                  fcnt_nxt = fcnt_r + 5'd1;
                end
                iacc_nxt  = '0;
                facc_nxt  = '0;
                flen_nxt  = '0;
                minus_nxt = 1'b0;
                point_nxt = 1'b0;
                bad_nxt   = 1'b0;
                first_nxt = '0;
              end
            end else if (fcnt_r == 5'd0) begin
              hdr_nxt = {hdr_r[31:0], in_byte_in};
            end else begin
              if (first_r == 8'd0) begin
                first_nxt = in_byte_in;
              end
              priority if (in_byte_in == nsfd_pkg::CH_MINUS) begin
                minus_nxt = 1'b1;
              end else if (in_byte_in == nsfd_pkg::CH_POINT) begin
                if (point_r) begin
                  bad_nxt = 1'b1;
                end
                point_nxt = 1'b1;
              end else if (b_digit) begin
                if (!point_r) begin
                  iacc_nxt = (iacc_r << 3) + (iacc_r << 1) + d32;
                end else if (flen_r < MAXF) begin
                  facc_nxt = (facc_r << 3) + (facc_r << 1) + FRAC_W'(d32);
                  flen_nxt = flen_r + FL_W'(1);
                end
              end else begin
                bad_nxt = 1'b1;
              end
            end
          end
        end
      end

      ST_MUL: begin
        if (mcnt_r == 4'd0) begin
          state_nxt = ST_NEXT;
        end else begin
          mreg_nxt = (mreg_r << 3) + (mreg_r << 1);
          mcnt_nxt = mcnt_r - 4'd1;
        end
      end

      ST_DIV: begin
        if (dcnt_r == 6'd0) begin
          state_nxt = ST_NEXT;
        end else begin
          rem_nxt  = ge ? diff[31:0] : r2[31:0];
          dq_nxt   = {dq_r[30:0], ge};
          dcnt_nxt = dcnt_r - 6'd1;
        end
      end

      ST_NEXT: begin
        state_nxt = ST_IDLE;
        unique case (phase_r)
          PH_VAL: begin
            v = mreg_r + 32'(wfrac_r);
            if (wminus_r) begin
              v = 32'd0 - v;
            end
            d = dec_r;
            if (wbad_r) begin
              v = '0;
              d = '0;
            end
            val_nxt   = v;
            dec_nxt   = d;
            rdec_nxt  = 3'(d);
            rslot_nxt = '0;
            rhi_nxt   = '0;
            rmid_nxt  = '0;
            rlo_nxt   = '0;
            rhemi_nxt = '0;
            unique case (kind_r)
              nsfd_pkg::KIND_GPGSV, nsfd_pkg::KIND_BDGSV: begin
                priority if (wf_r == 5'd2) begin
                  // Message number one starts a new satellite list.
                  if (v == 32'd1) begin
                    slot_nxt = '0;
                  end
                end else if (wf_r == 5'd3) begin
                  rq_nxt = nsfd_pkg::Q_VISIBLE;
                  emit   = 1'b1;
                end else if (wf_r >= 5'd4 && wf_r <= 5'd19) begin
                  rq_nxt    = nsfd_pkg::Q_SATID + 5'(wf_r[1:0]);
                  rslot_nxt = slot_r;
                  emit      = 1'b1;
                  if (wf_r[1:0] == 2'd3 && slot_r < SLOT_LAST) begin
                    slot_nxt = slot_r + 6'd1;
                  end
                end else begin
                  emit = 1'b0;
                end
              end
              nsfd_pkg::KIND_GNGGA: begin
                priority if (wf_r == 5'd6) begin
                  rq_nxt = nsfd_pkg::Q_STATUS;
                  emit   = 1'b1;
                end else if (wf_r == 5'd7) begin
                  rq_nxt = nsfd_pkg::Q_USED;
                  emit   = 1'b1;
                end else if (wf_r == 5'd9) begin
                  rq_nxt = nsfd_pkg::Q_ALT;
                  emit   = 1'b1;
                end else begin
                  emit = 1'b0;
                end
              end
              nsfd_pkg::KIND_GNGSA: begin
                priority if (wf_r == 5'd2) begin
                  rq_nxt = nsfd_pkg::Q_FIX;
                  emit   = 1'b1;
                end else if (wf_r >= 5'd15 && wf_r <= 5'd17) begin
                  rq_nxt = nsfd_pkg::Q_PDOP + (wf_r - 5'd15);
                  emit   = 1'b1;
                end else if (wf_r >= 5'd3 && wf_r < GSA_ID_END) begin
                  rq_nxt    = nsfd_pkg::Q_USEDID;
                  rslot_nxt = 6'(wf_r - 5'd3);
                  emit      = 1'b1;
                end else begin
                  emit = 1'b0;
                end
              end
              nsfd_pkg::KIND_GNRMC: begin
                priority if (wf_r == 5'd1) begin
                  rq_nxt    = nsfd_pkg::Q_TIME;
                  phase_nxt = PH_T_DEC;
                  div_go    = 1'b1;
                  div_a     = v;
                  div_b     = nsfd_pkg::pow10(4'(d));
                end else if (wf_r == 5'd9) begin
                  rq_nxt    = nsfd_pkg::Q_DATE;
                  phase_nxt = PH_T_S;
                  div_go    = 1'b1;
                  div_a     = v;
                  div_b     = 37'(nsfd_pkg::CENT);
                end else if (wf_r == 5'd3 || wf_r == 5'd5) begin
                  rq_nxt    = (wf_r == 5'd3) ? nsfd_pkg::Q_LAT : nsfd_pkg::Q_LON;
                  phase_nxt = PH_L_DEG;
                  div_go    = 1'b1;
                  div_a     = v;
                  div_b     = nsfd_pkg::pow10(4'(d) + 4'd2);
                end else if (wf_r == 5'd4 || wf_r == 5'd6) begin
                  rq_nxt    = (wf_r == 5'd4) ? nsfd_pkg::Q_NS : nsfd_pkg::Q_EW;
                  val_nxt   = '0;
                  rdec_nxt  = '0;
                  rhemi_nxt = whemi_r;
                  emit      = 1'b1;
                end else begin
                  emit = 1'b0;
                end
              end
              nsfd_pkg::KIND_GNVTG: begin
                if (wf_r == 5'd7) begin
                  rq_nxt = nsfd_pkg::Q_SPEED;
                  if (4'(d) < 4'd3) begin
                    phase_nxt = PH_SPEED;
                    mul_go    = 1'b1;
                    mul_a     = v;
                    mul_n     = 4'd3 - 4'(d);
                  end else begin
                    emit = 1'b1;
                  end
                end
              end
              default: begin
                emit = 1'b0;
              end
            endcase
          end
          PH_SPEED: begin
            val_nxt  = mreg_r;
            rdec_nxt = 3'd3;
            emit     = 1'b1;
          end
          PH_T_DEC: begin
            phase_nxt = PH_T_S;
            div_go    = 1'b1;
            div_a     = dq_r;
            div_b     = 37'(nsfd_pkg::CENT);
          end
          PH_T_S: begin
            rlo_nxt   = (rq_r == nsfd_pkg::Q_DATE) ? nsfd_pkg::YEAR_BASE + 12'(rem_r)
                                                   : 12'(rem_r);
            phase_nxt = PH_T_M;
            div_go    = 1'b1;
            div_a     = dq_r;
            div_b     = 37'(nsfd_pkg::CENT);
          end
          PH_T_M: begin
            rmid_nxt = 7'(rem_r);
            rhi_nxt  = (dq_r > 32'(nsfd_pkg::PART_CAP)) ? nsfd_pkg::PART_CAP : 7'(dq_r);
            emit     = 1'b1;
          end
          PH_L_DEG: begin
            deg_nxt = dq_r;
            if (4'(dec_r) <= 4'd5) begin
              phase_nxt = PH_L_SCL;
              mul_go    = 1'b1;
              mul_a     = rem_r;
              mul_n     = 4'd5 - 4'(dec_r);
            end else begin
              phase_nxt = PH_L_DOWN;
              div_go    = 1'b1;
              div_a     = rem_r;
              div_b     = nsfd_pkg::pow10(4'(dec_r) - 4'd5);
            end
          end
          PH_L_SCL: begin
            phase_nxt = PH_L_60;
            div_go    = 1'b1;
            div_a     = mreg_r;
            div_b     = 37'(nsfd_pkg::MIN_PER_DEG);
          end
          PH_L_DOWN: begin
            phase_nxt = PH_L_60;
            div_go    = 1'b1;
            div_a     = dq_r;
            div_b     = 37'(nsfd_pkg::MIN_PER_DEG);
          end
          PH_L_60: begin
            // Minutes as a fraction of a degree; the degrees are scaled next.
            val_nxt   = dq_r;
            phase_nxt = PH_L_DEGX;
            mul_go    = 1'b1;
            mul_a     = deg_r;
            mul_n     = 4'd5;
          end
          PH_L_DEGX: begin
            val_nxt  = mreg_r + val_r;
            rdec_nxt = 3'd5;
            emit     = 1'b1;
          end
          default: begin
            emit = 1'b0;
          end
        endcase
        if (emit) begin
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (div_go) begin
      dq_nxt    = div_a;
      rem_nxt   = '0;
      dvs_nxt   = div_b;
      dcnt_nxt  = 6'd32;
      state_nxt = ST_DIV;
    end
    if (mul_go) begin
      mreg_nxt  = mul_a;
      mcnt_nxt  = mul_n;
      state_nxt = ST_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_VAL;
      in_sent_r   <= 1'b0;
      hdr_r       <= '0;
      kind_r      <= nsfd_pkg::KIND_NONE;
      fcnt_r      <= '0;
      iacc_r      <= '0;
      facc_r      <= '0;
      flen_r      <= '0;
      minus_r     <= 1'b0;
      point_r     <= 1'b0;
      bad_r       <= 1'b0;
      first_r     <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      in_sent_r   <= in_sent_nxt;
      hdr_r       <= hdr_nxt;
      kind_r      <= kind_nxt;
      fcnt_r      <= fcnt_nxt;
      iacc_r      <= iacc_nxt;
      facc_r      <= facc_nxt;
      flen_r      <= flen_nxt;
      minus_r     <= minus_nxt;
      point_r     <= point_nxt;
      bad_r       <= bad_nxt;
      first_r     <= first_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wf_r     <= wf_nxt;
    wbad_r   <= wbad_nxt;
    wminus_r <= wminus_nxt;
    wfrac_r  <= wfrac_nxt;
    dec_r    <= dec_nxt;
    whemi_r  <= whemi_nxt;
    mreg_r   <= mreg_nxt;
    mcnt_r   <= mcnt_nxt;
    dq_r     <= dq_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    dcnt_r   <= dcnt_nxt;
    deg_r    <= deg_nxt;
    val_r    <= val_nxt;
    rq_r     <= rq_nxt;
    rslot_r  <= rslot_nxt;
    rdec_r   <= rdec_nxt;
    rhi_r    <= rhi_nxt;
    rmid_r   <= rmid_nxt;
    rlo_r    <= rlo_nxt;
    rhemi_r  <= rhemi_nxt;
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_sentence_kind   <= kind_r;
      out_quantity        <= rq_r;
      out_slot            <= rslot_r;
      out_value           <= signed'(val_r);
      out_decimals        <= rdec_r;
      out_part_high       <= rhi_r;
      out_part_mid        <= rmid_r;
      out_part_low        <= rlo_r;
      out_hemisphere_char <= rhemi_r;
    end
  end

endmodule

/* rtl/nsfd_checker.sv */
module nsfd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         in_byte_in,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_sentence_kind,
  input logic [4:0]         out_quantity,
  input logic [5:0]         out_slot,
  input logic signed [31:0] out_value,
  input logic [2:0]         out_decimals,
  input logic [6:0]         out_part_high,
  input logic [6:0]         out_part_mid,
  input logic [11:0]        out_part_low,
  input logic [7:0]         out_hemisphere_char
);

  // A waiting result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_quantity))
    else $error("result changed while stalled");

  // Results only come from a recognised sentence and a known quantity.
  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sentence_kind <= nsfd_pkg::KIND_GNVTG &&
                  out_quantity <= nsfd_pkg::Q_LAST)
    else $error("unknown sentence kind or quantity on output");

  // Hemisphere results carry only the character.
  a_hemi_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_quantity == nsfd_pkg::Q_NS || out_quantity == nsfd_pkg::Q_EW)
    |-> out_value == 32'sd0 && out_decimals == 3'd0)
    else $error("hemisphere result has a value");

  // Latitude and longitude always come with five fraction digits.
  a_deg_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_quantity == nsfd_pkg::Q_LAT || out_quantity == nsfd_pkg::Q_LON)
    |-> out_decimals == 3'd5)
    else $error("position result with wrong decimals");

endmodule

bind nmea_sentence_field_decoder nsfd_checker u_nsfd_checker (.*);

/* tb/nmea_sentence_field_decoder_test.sv */
`timescale 1ns / 100ps

module nmea_sentence_field_decoder_test;
  import nsfd_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BYTES = 1650;
  localparam int FRAC_MAX     = MAX_FRACTION_DIGITS_DEF;
  localparam int USED_IDS     = USED_SAT_FIELDS_DEF;
  localparam int SLOT_COUNT   = SATELLITE_SLOTS_DEF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  qty;
    logic [5:0]  slot;
    logic [31:0] value;
    logic [2:0]  decimals;
    logic [6:0]  hi;
    logic [6:0]  mid;
    logic [11:0] lo;
    logic [7:0]  hemi;
  } field_t;

  typedef struct {
    string  text;
    bit     typed;
    field_t want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte_in;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_sentence_kind;
  logic [4:0]  out_quantity;
  logic [5:0]  out_slot;
  logic signed [31:0] out_value;
  logic [2:0]  out_decimals;
  logic [6:0]  out_part_high;
  logic [6:0]  out_part_mid;
  logic [11:0] out_part_low;
  logic [7:0]  out_hemisphere_char;

  nmea_sentence_field_decoder dut (.*);

  // Decoder state mirrored by the predictor.
  bit          open_sentence;
  logic [39:0] header_bytes;
  logic [2:0]  cur_kind;
  logic [4:0]  field_no;
  logic [31:0] int_part;
  logic [31:0] frac_part;
  int          frac_digits;
  bit          negative;
  bit          has_point;
  bit          malformed;
  logic [7:0]  first_char;
  logic [5:0]  sat_slot;

  field_t      pending_fields[$];
  bit          override_armed;
  field_t      override_field;
  bit          no_idle;
  int          error_count;
  int          cycle_count;
  int          sent_bytes;
  row_t        rows[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned ten_pow(int n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  function automatic void clear_field_state();
    int_part = 0;
    frac_part = 0;
    frac_digits = 0;
    negative = 0;
    has_point = 0;
    malformed = 0;
    first_char = 8'h00;
  endfunction

  function automatic logic [31:0] minutes_to_degrees(logic [31:0] raw, int dec);
    longint unsigned p, deg, rest, scaled;
    p = ten_pow(dec + 2);
    deg = longint'(raw) / p;
    rest = longint'(raw) % p;
    scaled = (dec <= 5) ? rest * ten_pow(5 - dec) : rest / ten_pow(dec - 5);
    return 32'(deg * 100000 + scaled / 60);
  endfunction

  function automatic field_t make_field(logic [2:0] k, logic [4:0] q, int slot,
                                        logic [31:0] v, int dec);
    field_t f;
    f = '0;
    f.kind = k;
    f.qty = q;
    f.slot = 6'(slot);
    f.value = v;
    f.decimals = 3'(dec);
    return f;
  endfunction

  function automatic bit close_field(logic [7:0] term, output field_t r);
    bit          bad;
    logic [31:0] v;
    logic [31:0] t;
    logic [31:0] hour;
    int          dec;
    int          f;
    logic [4:0]  q;
    bad = malformed || (term != CH_COMMA && term != CH_STAR);
    v = 0;
    dec = 0;
    f = field_no;
    r = '0;
    if (!bad) begin
      dec = frac_digits;
      v = 32'(longint'(int_part) * ten_pow(dec) + longint'(frac_part));
      if (negative) v = -v;
    end
    case (cur_kind)
      KIND_GPGSV, KIND_BDGSV: begin
        if (f == 2) begin
          if (v == 1) sat_slot = 0;
          return 0;
        end
        if (f == 3) begin
          r = make_field(cur_kind, Q_VISIBLE, 0, v, dec);
          return 1;
        end
        if (f >= 4 && f <= 19) begin
          q = Q_SATID + 5'((f - 4) % 4);
          r = make_field(cur_kind, q, sat_slot, v, dec);
          if (q == Q_SNR && sat_slot + 1 < SLOT_COUNT) sat_slot++;
          return 1;
        end
        return 0;
      end
      KIND_GNGGA: begin
        if (f == 6) r = make_field(cur_kind, Q_STATUS, 0, v, dec);
        else if (f == 7) r = make_field(cur_kind, Q_USED, 0, v, dec);
        else if (f == 9) r = make_field(cur_kind, Q_ALT, 0, v, dec);
        else return 0;
        return 1;
      end
      KIND_GNGSA: begin
        if (f == 2) r = make_field(cur_kind, Q_FIX, 0, v, dec);
        else if (f >= 15 && f <= 17) r = make_field(cur_kind, Q_PDOP + 5'(f - 15), 0, v, dec);
        else if (f >= 3 && f < 3 + USED_IDS) r = make_field(cur_kind, Q_USEDID, f - 3, v, dec);
        else return 0;
        return 1;
      end
      KIND_GNRMC: begin
        if (f == 1 || f == 9) begin
          t = (f == 1) ? 32'(longint'(v) / ten_pow(dec)) : v;
          hour = t / 10000;
          if (hour > 99) hour = 99;
          r = make_field(cur_kind, (f == 1) ? Q_TIME : Q_DATE, 0, v, dec);
          r.hi = 7'(hour);
          r.mid = 7'((t / 100) % 100);
          r.lo = (f == 1) ? 12'(t % 100) : 12'(2000 + t % 100);
          return 1;
        end
        if (f == 3 || f == 5) begin
          r = make_field(cur_kind, (f == 3) ? Q_LAT : Q_LON, 0,
                         minutes_to_degrees(v, dec), 5);
          return 1;
        end
        if (f == 4 || f == 6) begin
          r = make_field(cur_kind, (f == 4) ? Q_NS : Q_EW, 0, 0, 0);
          r.hemi = (first_char != 0) ? first_char : term;
          return 1;
        end
        return 0;
      end
      KIND_GNVTG: begin
        if (f != 7) return 0;
        if (dec < 3) begin
          v = 32'(longint'(v) * ten_pow(3 - dec));
          dec = 3;
        end
        r = make_field(cur_kind, Q_SPEED, 0, v, dec);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic bit decode_char(logic [7:0] b, output field_t r);
    bit ends;
    bit got;
    got = 0;
    r = '0;
    if (b == CH_DOLLAR) begin
      open_sentence = 1;
      header_bytes = 0;
      cur_kind = KIND_NONE;
      field_no = 0;
      clear_field_state();
      return 0;
    end
    if (!open_sentence) return 0;
    ends = (b == CH_STAR) || (b < CH_SPACE) || (b > CH_LOW_Z);
    if (b == CH_COMMA || ends) begin
      if (field_no == 0) begin
        if (b == CH_COMMA) begin
          if (header_bytes == 40'("GPGSV")) cur_kind = KIND_GPGSV;
          else if (header_bytes == 40'("BDGSV")) cur_kind = KIND_BDGSV;
          else if (header_bytes == 40'("GNGGA")) cur_kind = KIND_GNGGA;
          else if (header_bytes == 40'("GNGSA")) cur_kind = KIND_GNGSA;
          else if (header_bytes == 40'("GNRMC")) cur_kind = KIND_GNRMC;
          else if (header_bytes == 40'("GNVTG")) cur_kind = KIND_GNVTG;
        end
      end else if (cur_kind != KIND_NONE) begin
        got = close_field(b, r);
      end
      if (ends) begin
        open_sentence = 0;
      end else begin
        if (field_no < 31) field_no++;
        clear_field_state();
      end
      return got;
    end
    if (field_no == 0) begin
      header_bytes = {header_bytes[31:0], b};
      return 0;
    end
    if (first_char == 0) first_char = b;
    if (b == CH_MINUS) begin
      negative = 1;
    end else if (b == CH_POINT) begin
      if (has_point) malformed = 1;
      has_point = 1;
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      if (!has_point) begin
        int_part = int_part * 10 + 32'(b - CH_ZERO);
      end else if (frac_digits < FRAC_MAX) begin
        frac_part = frac_part * 10 + 32'(b - CH_ZERO);
        frac_digits++;
      end
    end else begin
      malformed = 1;
    end
    return 0;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic send_char(logic [7:0] b);
    field_t r;
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (!in_ready);
    if (decode_char(b, r)) begin
      if (override_armed) begin
        pending_fields.push_back(override_field);
        override_armed = 0;
      end else begin
        pending_fields.push_back(r);
      end
    end
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic string random_number(int max_len);
    string s;
    int n;
    int pick;
    s = "";
    n = $urandom_range(0, max_len);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
      else if (pick < 88) s = {s, "."};
      else if (pick < 95) s = {s, "-"};
      else s = {s, string'(8'($urandom_range(8'h41, CH_LOW_Z)))};
    end
    return s;
  endfunction

  task automatic send_random_sentence();
    string hdr[6] = '{"GPGSV", "BDGSV", "GNGGA", "GNGSA", "GNRMC", "GNVTG"};
    string s;
    string fld;
    int k;
    int nf;
    int pick;
    k = $urandom_range(0, 6);
    s = (k == 6) ? {"$", random_number(6)} : {"$", hdr[k]};
    nf = $urandom_range(1, 22);
    for (int f = 1; f <= nf; f++) begin
      pick = $urandom_range(0, 9);
      if (k < 2 && f == 2 && pick < 5) fld = "1";
      else if (k == 4 && (f == 4 || f == 6) && pick < 8)
        fld = string'(8'(pick < 2 ? "N" : pick < 4 ? "S" : pick < 6 ? "E" : "W"));
      else if (k == 4 && (f == 1 || f == 3 || f == 5 || f == 9) && pick < 7)
        fld = {random_number(0), $sformatf("%0d.%0d", $urandom_range(0, 999999),
                                            $urandom_range(0, 9999))};
      else fld = random_number(pick < 2 ? 14 : 7);
      s = {s, ",", fld};
    end
    send_text(s);
    pick = $urandom_range(0, 9);
    if (pick < 6) send_text($sformatf("*%02X\r\n", $urandom_range(0, 255)));
    else if (pick < 8) send_char(8'($urandom_range(0, 31)));
    else if (pick < 9) send_char(8'($urandom_range(8'h7B, 8'hFF)));
  endtask

  task automatic add_row(string s, bit typed, field_t want);
    row_t r;
    r.text = s;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endtask

  always @(posedge clk) begin
    field_t got;
    field_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_sentence_kind, out_quantity, out_slot, out_value, out_decimals,
              out_part_high, out_part_mid, out_part_low, out_hemisphere_char};
      if (pending_fields.size() == 0) begin
        report_mismatch($sformatf("unexpected field %p", got));
      end else begin
        want = pending_fields.pop_front();
        if (got.kind != want.kind) report_mismatch($sformatf("kind %0d want %0d",
                                                   got.kind, want.kind));
        if (got.qty != want.qty) report_mismatch($sformatf("quantity %0d want %0d",
                                                 got.qty, want.qty));
        if (got.slot != want.slot) report_mismatch($sformatf("slot %0d want %0d",
                                                   got.slot, want.slot));
        if (got.value != want.value) report_mismatch($sformatf("value %0d want %0d",
                                                     $signed(got.value), $signed(want.value)));
        if (got.decimals != want.decimals) report_mismatch($sformatf("decimals %0d want %0d",
                                                           got.decimals, want.decimals));
        if (got.hi != want.hi) report_mismatch($sformatf("part_high %0d want %0d",
                                               got.hi, want.hi));
        if (got.mid != want.mid) report_mismatch($sformatf("part_mid %0d want %0d",
                                                 got.mid, want.mid));
        if (got.lo != want.lo) report_mismatch($sformatf("part_low %0d want %0d",
                                               got.lo, want.lo));
        if (got.hemi != want.hemi) report_mismatch($sformatf("hemisphere %0h want %0h",
                                                   got.hemi, want.hemi));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: holds ready low for a random pause before each transaction, with no pause while no_idle is set.
  initial begin
    int hold;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hold = no_idle ? 0 : $urandom_range(0, 3);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    field_t w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte_in = 8'h00;
    no_idle = 0;
    error_count = 0;
    cycle_count = 0;
    sent_bytes = 0;
    override_armed = 0;
    open_sentence = 0;
    header_bytes = 0;
    cur_kind = KIND_NONE;
    field_no = 0;
    sat_slot = 0;
    clear_field_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row("$GNGGA,1,2,3,4,5,6,", 1, make_field(KIND_GNGGA, Q_STATUS, 0, 6, 0));
    add_row("$GNGGA,,,,,,1.2.3,A,,x9*", 1, make_field(KIND_GNGGA, Q_STATUS, 0, 0, 0));
    w = make_field(KIND_GNVTG, Q_SPEED, 0, 12500, 3);
    add_row("$GNVTG,,,,,,,12.5,K*", 1, w);
    w.value = 0;
    add_row("$GNVTG,,,,,,,2147483647.99999\n", 1, w);
    add_row("$GNGGA,,,,,,-4294967295,,-0.123456789*", 0, '0);
    add_row("$GPGSV,3,1,12,01,-05,359,45,02,90,000,99*", 0, '0);
    add_row("$BDGSV,1,2,9,33,12.123456,2,3,4*", 0, '0);
    add_row("$GNGSA,A,3,1,2,3,4,5,6,7,8,9,10,11,12,1.5,2.5,3.5,,*", 0, '0);
    add_row("$GNRMC,235959.99,A,4916.45,N,12311.12,W,0,0,311299,,*", 0, '0);
    add_row("$GNRMC,9999999999,V,,,,,,,991399*", 0, '0);
    add_row("$GNRMC,1,A,-1,S,99999999.99999,E{", 0, '0);
    add_row("$XXGGA,1,2,3,4,5,6*$GNG$GNGGA,,,,,,7*junk,8,", 0, '0);
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        override_armed = 1;
        override_field = rows[i].want;
      end
      send_text(rows[i].text);
    end

    // Let every result of the directed part arrive before the random traffic starts.
    drain_results();

    sent_bytes = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      no_idle = ((sent_bytes / 200) % 4) == 3;
      if ($urandom_range(0, 9) == 0) send_char(8'($urandom_range(0, 255)));
      else send_random_sentence();
    end
    no_idle = 0;
    drain_results();
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* nmea_sentence_field_decoder.f */
rtl/nsfd_pkg.sv
rtl/nmea_sentence_field_decoder.sv
rtl/nsfd_checker.sv
tb/nmea_sentence_field_decoder_test.sv
